>>> design/sfr_pkg.sv
// Shared types, frame layout constants and the CRC-16 byte update for the
// sensor frame receiver. No dependencies.
`default_nettype none

package sfr_pkg;

    localparam int FRAME_LEN  = 21;
    localparam int POS_W      = 5;
    localparam int POS_CRC_LO = FRAME_LEN - 3;
    localparam int POS_CRC_HI = FRAME_LEN - 2;
    localparam int POS_TAIL   = FRAME_LEN - 1;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 8'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TAIL = 2'd1,
        ST_BAD_CRC  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            frame_status;
        logic signed [15:0] distance_a;
        logic signed [15:0] distance_b;
        logic signed [15:0] distance_c;
        logic signed [15:0] distance_d;
        logic signed [15:0] distance_e;
        logic [7:0]         switch_state;
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
        logic signed [15:0] particulate;
    } t_result;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/sfr_byte_if.sv
// Byte channel: valid/ready handshake carrying one received serial byte.
// Depends on nothing.
`default_nettype none

interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/sfr_result_if.sv
// Result channel: valid/ready handshake carrying one decoded frame.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_result_if;
    import sfr_pkg::*;

    logic               valid;
    logic               ready;
    t_status            frame_status;
    logic signed [15:0] distance_a;
    logic signed [15:0] distance_b;
    logic signed [15:0] distance_c;
    logic signed [15:0] distance_d;
    logic signed [15:0] distance_e;
    logic [7:0]         switch_state;
    logic signed [15:0] temperature;
    logic signed [15:0] humidity;
    logic signed [15:0] particulate;

    modport source (output valid, output frame_status, output distance_a, output distance_b,
                    output distance_c, output distance_d, output distance_e,
                    output switch_state, output temperature, output humidity,
                    output particulate, input ready);
    modport sink   (input valid, input frame_status, input distance_a, input distance_b,
                    input distance_c, input distance_d, input distance_e,
                    input switch_state, input temperature, input humidity,
                    input particulate, output ready);
endinterface

`default_nettype wire

>>> design/sfr_collector.sv
// Header hunt, byte position, running CRC and frame byte store.
// Decodes the finished frame combinationally. Depends on sfr_pkg.
`default_nettype none

module sfr_collector (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fire,
    input  wire logic [7:0]               i_byte,
    input  wire logic [7:0]               i_header,
    input  wire logic [7:0]               i_tail,
    output logic                          o_last,
    output logic                          o_done,
    output sfr_pkg::t_result              o_result
);
    import sfr_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(POS_TAIL);
    localparam logic [POS_W-1:0] CRC_END   = POS_W'(POS_CRC_LO);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_store [1:POS_CRC_HI];
    t_status          status;

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (i_fire) begin
            if (r_pos == '0) begin
                if (i_byte == i_header) begin
                    n_pos = POS_W'(1);
                    n_crc = crc_feed(CRC_PRESET, i_byte);
                end
            end else if (r_pos == LAST_POS) begin
                n_pos = '0;
                n_crc = CRC_PRESET;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos < CRC_END) begin
                    n_crc = crc_feed(r_crc, i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_PRESET;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Payload store: no reset, every entry is written before the frame ends.
    always_ff @(posedge i_clk) begin
        if (i_fire && r_pos != '0 && r_pos != LAST_POS) begin
            r_store[r_pos] <= i_byte;
        end
    end

    assign o_last = (r_pos == LAST_POS);
    assign o_done = i_fire && o_last;

    // Tail is checked first; the tail byte is the one on the input now.
    always_comb begin
        if (i_byte != i_tail) begin
            status = ST_BAD_TAIL;
        end else if (r_store[POS_CRC_LO] != r_crc[7:0] || r_store[POS_CRC_HI] != r_crc[15:8]) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.frame_status = status;
        if (status == ST_OK) begin
            o_result.distance_a   = $signed({r_store[1],  r_store[2]});
            o_result.distance_b   = $signed({r_store[3],  r_store[4]});
            o_result.distance_c   = $signed({r_store[5],  r_store[6]});
            o_result.distance_d   = $signed({r_store[7],  r_store[8]});
            o_result.distance_e   = $signed({r_store[9],  r_store[10]});
            o_result.switch_state = r_store[11];
            o_result.temperature  = $signed({r_store[12], r_store[13]});
            o_result.humidity     = $signed({r_store[14], r_store[15]});
            o_result.particulate  = $signed({r_store[16], r_store[17]});
        end
    end

endmodule

`default_nettype wire

>>> design/sfr_out_reg.sv
// Result register: holds one decoded frame until the sink takes the beat.
// Depends on sfr_pkg.
`default_nettype none

module sfr_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire sfr_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output sfr_pkg::t_result      o_result
);
    import sfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> design/sensor_frame_receiver_crc16.sv
// Latency: a result beat is valid the cycle after the last (tail) byte of a frame is accepted.
// Throughput: one byte per cycle; a frame of 21 bytes gives one result beat.
// The byte side stalls only when the tail byte is offered while the previous result is
// still held in the result register and the sink is not taking it.
// Reset (synchronous, active low): hunt for header, CRC preset, registers read zero,
// no result pending; the frame store itself is not cleared.
`default_nettype none

module sensor_frame_receiver_crc16 (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    sfr_byte_if.sink                                i_rx,
    sfr_result_if.source                            o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sfr_pkg::*;

    logic [7:0] r_header;
    logic [7:0] r_tail;
    logic       rx_fire;
    logic       last;
    logic       done;
    logic       out_valid;
    t_result    frame_result;
    t_result    out_result;

    // Configuration: writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            r_tail   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_TAIL:   r_tail   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Only the tail byte produces a result, so hold the byte side just for that
    // beat while the result register is full and not draining.
    assign i_rx.ready = !last || !out_valid || o_res.ready;
    assign rx_fire    = i_rx.valid && i_rx.ready;

    sfr_collector u_collector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (rx_fire),
        .i_byte   (i_rx.rx_byte),
        .i_header (r_header),
        .i_tail   (r_tail),
        .o_last   (last),
        .o_done   (done),
        .o_result (frame_result)
    );

    sfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (done),
        .i_result (frame_result),
        .i_ready  (o_res.ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // Spread the held frame onto the result channel.
    assign o_res.valid        = out_valid;
    assign o_res.frame_status = out_result.frame_status;
    assign o_res.distance_a   = out_result.distance_a;
    assign o_res.distance_b   = out_result.distance_b;
    assign o_res.distance_c   = out_result.distance_c;
    assign o_res.distance_d   = out_result.distance_d;
    assign o_res.distance_e   = out_result.distance_e;
    assign o_res.switch_state = out_result.switch_state;
    assign o_res.temperature  = out_result.temperature;
    assign o_res.humidity     = out_result.humidity;
    assign o_res.particulate  = out_result.particulate;

endmodule

`default_nettype wire

>>> design/sfr_checker.sv
// Port-level checks for the sensor frame receiver, bound to the top level.
// Depends on sfr_pkg.
`default_nettype none

module sfr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire sfr_pkg::t_status   i_status,
    input wire logic [15:0]        i_dist_a,
    input wire logic [15:0]        i_dist_e,
    input wire logic [7:0]         i_switch,
    input wire logic [15:0]        i_temp,
    input wire logic [15:0]        i_part
);
    import sfr_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_temp))
        else $error("stalled result beat changed");

    // Byte side stalls only behind a full, stalled result register.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("byte side stalled without a pending result");

    // Failed frames carry zero data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |->
            i_dist_a == '0 && i_dist_e == '0 && i_switch == '0 && i_temp == '0 && i_part == '0)
        else $error("failed frame carries data");

    // Status code 3 is never produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status == ST_OK || i_status == ST_BAD_TAIL || i_status == ST_BAD_CRC)
        else $error("undefined frame status");

endmodule

bind sensor_frame_receiver_crc16 sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.frame_status),
    .i_dist_a    (o_res.distance_a),
    .i_dist_e    (o_res.distance_e),
    .i_switch    (o_res.switch_state),
    .i_temp      (o_res.temperature),
    .i_part      (o_res.particulate)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for sensor_frame_receiver_crc16: drives serial byte beats and register
// writes, predicts every decoded frame in SystemVerilog, checks result beats field by field.
// Depends on sfr_pkg, sfr_byte_if, sfr_result_if and the receiver itself.
`default_nettype none

module tb;
    import sfr_pkg::*;

    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY  = 16'hA001;
    localparam int unsigned DRAIN_CYCLES = 4;     // result is registered: it shows the cycle after the tail beat
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
    // Worst quiet stretch in a good run is the hold-off above plus a few sender gaps.
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned RAND_BEATS   = 300;

    // How a frame is damaged on its way in.
    typedef enum int {
        SH_GOOD,
        SH_BAD_TAIL,
        SH_BAD_CRC_LO,
        SH_BAD_CRC_HI,
        SH_BOTH_BAD
    } t_shape;

    // Receiver behavior between long hold-offs.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN
    } t_take_mode;

    // One row of the directed table: optional register setup, leading noise, one frame.
    typedef struct {
        bit          set_cfg;
        logic [7:0]  hdr;
        logic [7:0]  tail;
        int unsigned noise;
        t_shape      shape;
        bit          rand_body;
        logic [15:0] word;
        logic [7:0]  sw;
        bit          typed;
        t_status     status;
    } t_row;

    // Expected frame typed into the table; used in place of the prediction when set.
    typedef struct {
        bit      typed;
        t_result res;
    } t_pin;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfr_byte_if   rx_link();
    sfr_result_if frame_link();

    sensor_frame_receiver_crc16 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_link),
        .o_res      (frame_link),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Byte beats waiting to go out, frames the predictor says must come back.
    logic [7:0] rx_stream [$];
    t_result    pending_frames [$];
    t_pin       pinned_q [$];

    // Register values the frame builder uses.
    logic [7:0] cur_hdr  = 8'h00;
    logic [7:0] cur_tail = 8'h00;

    // Predictor state: own copy of the registers, position, running CRC and frame bytes.
    logic [7:0]  p_hdr  = 8'h00;
    logic [7:0]  p_tail = 8'h00;
    int unsigned p_pos  = 0;
    logic [15:0] p_crc  = CRC_SEED;
    logic [7:0]  p_store [FRAME_LEN];

    int unsigned beats_in     = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // Sender and receiver pacing.
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    bit          hold_req   = 1'b0;
    t_take_mode  take_mode  = RX_OPEN;
    logic [7:0]  stall_pat  = 8'h01;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive every block input to a known value before the first edge.
    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        rx_link.valid        = 1'b0;
        rx_link.rx_byte      = 8'h00;
        frame_link.ready     = 1'b0;
        foreach (p_store[i]) p_store[i] = 8'h00;
    end

    // Modbus CRC-16, reflected, one byte LSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) crc = crc ^ MODBUS_POLY;
        end
        return crc;
    endfunction

    // Mirror one register write into the predictor; stray indexes are dropped.
    function automatic void latch_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_HEADER) begin
            p_hdr = val;
        end else if (idx == CFG_TAIL) begin
            p_tail = val;
        end
    endfunction

    // Advance the predictor by one accepted byte; return 1 when a frame completes.
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        t_status st;
        r = '0;
        // Hunt: drop everything but the header byte.
        if (p_pos == 0 || p_pos >= FRAME_LEN) begin
            if (b == p_hdr) begin
                p_store[0] = b;
                p_crc      = crc16_step(CRC_SEED, b);
                p_pos      = 1;
            end else begin
                p_pos = 0;
            end
            return 1'b0;
        end
        // In a frame every byte is data, header values included.
        p_store[p_pos] = b;
        if (p_pos < POS_CRC_LO) p_crc = crc16_step(p_crc, b);
        p_pos++;
        if (p_pos < FRAME_LEN) return 1'b0;

        // Tail is judged before the CRC.
        if (p_store[POS_TAIL] != p_tail) begin
            st = ST_BAD_TAIL;
        end else if ({p_store[POS_CRC_HI], p_store[POS_CRC_LO]} != p_crc) begin
            st = ST_BAD_CRC;
        end else begin
            st = ST_OK;
        end
        r.frame_status = st;
        if (st == ST_OK) begin
            r.distance_a   = {p_store[1],  p_store[2]};
            r.distance_b   = {p_store[3],  p_store[4]};
            r.distance_c   = {p_store[5],  p_store[6]};
            r.distance_d   = {p_store[7],  p_store[8]};
            r.distance_e   = {p_store[9],  p_store[10]};
            r.switch_state = p_store[11];
            r.temperature  = {p_store[12], p_store[13]};
            r.humidity     = {p_store[14], p_store[15]};
            r.particulate  = {p_store[16], p_store[17]};
        end
        p_pos = 0;
        p_crc = CRC_SEED;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] seen, input logic [15:0] want);
        if (seen !== want) begin
            report_mismatch($sformatf("frame %0d %s got %h expected %h",
                                      results_seen, name, seen, want));
        end
    endtask

    // Queue leading garbage; keep it off the header value unless asked.
    task automatic queue_noise(input int unsigned n, input bit allow_hdr);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (!allow_hdr && b == cur_hdr) b = ~b;
            rx_stream.push_back(b);
        end
    endtask

    // Build one frame from the current registers, damage it as asked, queue the first keep bytes.
    task automatic queue_frame(input t_shape shape, input bit rand_body, input logic [15:0] word,
                               input logic [7:0] sw, input int unsigned keep);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] crc;
        int unsigned roll;
        fb[0] = cur_hdr;
        for (int i = 1; i < POS_CRC_LO; i++) begin
            if (rand_body) begin
                // Salt the body with header and tail values now and then.
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    fb[i] = cur_hdr;
                end else if (roll == 1) begin
                    fb[i] = cur_tail;
                end else begin
                    fb[i] = 8'($urandom_range(0, 255));
                end
            end else if (i == 11) begin
                fb[i] = sw;
            end else if ((i < 11) == (i % 2 == 1)) begin
                fb[i] = word[15:8];
            end else begin
                fb[i] = word[7:0];
            end
        end
        crc = CRC_SEED;
        for (int i = 0; i < POS_CRC_LO; i++) crc = crc16_step(crc, fb[i]);
        fb[POS_CRC_LO] = crc[7:0];
        fb[POS_CRC_HI] = crc[15:8];
        fb[POS_TAIL]   = cur_tail;
        case (shape)
            SH_BAD_TAIL: begin
                fb[POS_TAIL] ^= 8'(1 << $urandom_range(0, 7));
            end
            SH_BAD_CRC_LO: begin
                fb[POS_CRC_LO] ^= 8'(1 << $urandom_range(0, 7));
            end
            SH_BAD_CRC_HI: begin
                fb[POS_CRC_HI] ^= 8'(1 << $urandom_range(0, 7));
            end
            SH_BOTH_BAD: begin
                fb[POS_TAIL]   ^= 8'(1 << $urandom_range(0, 7));
                fb[POS_CRC_LO] ^= 8'(1 << $urandom_range(0, 7));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < FRAME_LEN && i < keep; i++) rx_stream.push_back(fb[i]);
    endtask

    // Wait for every queued beat to go in and every expected frame to come out,
    // then wait out the drain interval so any frame work in flight finishes.
    task automatic settle();
        while (rx_stream.size() != 0 || rx_link.valid || pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write header, tail and one out-of-range index, one per edge, with no gap in the enable.
    task automatic program_regs(input logic [7:0] hdr, input logic [7:0] tl);
        logic [CFG_IDX_W-1:0]  stray_idx;
        logic [CFG_DATA_W-1:0] stray_val;
        stray_idx = CFG_IDX_W'($urandom_range(CFG_TAIL + 1, (1 << CFG_IDX_W) - 1));
        stray_val = CFG_DATA_W'($urandom_range(0, 255));
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEADER;
        cfg_data <= hdr;
        @(posedge i_clk);
        latch_reg(CFG_HEADER, hdr);
        cfg_idx  <= CFG_TAIL;
        cfg_data <= tl;
        @(posedge i_clk);
        latch_reg(CFG_TAIL, tl);
        cfg_idx  <= stray_idx;
        cfg_data <= stray_val;
        @(posedge i_clk);
        latch_reg(stray_idx, stray_val);
        cfg_we   <= 1'b0;
        cur_hdr  = hdr;
        cur_tail = tl;
    endtask

    // Sender: bursts of random length with random gaps; hold a beat until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_link.valid   <= 1'b0;
            rx_link.rx_byte <= 8'h00;
        end else if (!(rx_link.valid && !rx_link.ready)) begin
            if (rx_link.valid) rx_stream.delete(0);
            if (gap_left != 0) begin
                gap_left--;
                rx_link.valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
                rx_link.valid   <= 1'b1;
                rx_link.rx_byte <= rx_stream[0];
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    // Start a new burst; a third of them run with no gap at all.
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                rx_link.valid <= 1'b0;
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_link.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            frame_link.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            frame_link.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: take_mode = RX_OPEN;
                    1: take_mode = RX_COIN;
                    default: take_mode = RX_PATTERN;
                endcase
                mode_left = $urandom_range(16, 96);
                stall_pat = 8'($urandom_range(0, 255)) | 8'h01;
            end else begin
                mode_left--;
            end
            case (take_mode)
                RX_OPEN: begin
                    frame_link.ready <= 1'b1;
                end
                RX_COIN: begin
                    frame_link.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    frame_link.ready <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[7:1]};
                end
            endcase
        end
    end

    // Predict on every byte beat, check every result beat, and watch for a hang.
    always @(posedge i_clk) begin : frame_check
        t_result want;
        t_pin    pin;
        if (i_rst_n) begin
            quiet_cycles++;
            if (rx_link.valid && rx_link.ready) begin
                quiet_cycles = 0;
                beats_in++;
                if (decode_byte(rx_link.rx_byte, want)) begin
                    // Directed rows may carry the expected frame typed in.
                    if (pinned_q.size() != 0) begin
                        pin = pinned_q.pop_front();
                        if (pin.typed) want = pin.res;
                    end
                    pending_frames.push_back(want);
                end
            end
            if (frame_link.valid && frame_link.ready) begin
                quiet_cycles = 0;
                results_seen++;
                if (pending_frames.size() == 0) begin
                    report_mismatch($sformatf("frame %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = pending_frames.pop_front();
                    cmp_field("frame_status", 16'(frame_link.frame_status),
                              16'(want.frame_status));
                    cmp_field("distance_a", frame_link.distance_a, want.distance_a);
                    cmp_field("distance_b", frame_link.distance_b, want.distance_b);
                    cmp_field("distance_c", frame_link.distance_c, want.distance_c);
                    cmp_field("distance_d", frame_link.distance_d, want.distance_d);
                    cmp_field("distance_e", frame_link.distance_e, want.distance_e);
                    cmp_field("switch_state", 16'(frame_link.switch_state),
                              16'(want.switch_state));
                    cmp_field("temperature", frame_link.temperature, want.temperature);
                    cmp_field("humidity", frame_link.humidity, want.humidity);
                    cmp_field("particulate", frame_link.particulate, want.particulate);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row        plan [11];
        t_pin        pin;
        int unsigned base_beats;
        int unsigned phase;
        int unsigned pick;
        t_shape      shape;
        logic [7:0]  hdr;
        logic [7:0]  tl;

        // Directed frames. Typed rows: status and fields read straight off the frame layout.
        plan = '{
            // after reset: header and tail both zero, all-zero body
            '{1'b0, 8'h00, 8'h00, 0, SH_GOOD,       1'b0, 16'h0000, 8'h00, 1'b1, ST_OK},
            // register extremes, field extremes
            '{1'b1, 8'hFF, 8'hFF, 2, SH_GOOD,       1'b0, 16'h7FFF, 8'hFF, 1'b1, ST_OK},
            '{1'b0, 8'h00, 8'h00, 1, SH_GOOD,       1'b0, 16'h8000, 8'h00, 1'b1, ST_OK},
            '{1'b0, 8'h00, 8'h00, 0, SH_GOOD,       1'b0, 16'hFFFF, 8'h80, 1'b1, ST_OK},
            // each error code, tail judged before the CRC
            '{1'b0, 8'h00, 8'h00, 0, SH_BAD_TAIL,   1'b0, 16'h1234, 8'h56, 1'b1, ST_BAD_TAIL},
            '{1'b0, 8'h00, 8'h00, 0, SH_BAD_CRC_LO, 1'b0, 16'h0001, 8'h01, 1'b1, ST_BAD_CRC},
            '{1'b0, 8'h00, 8'h00, 0, SH_BAD_CRC_HI, 1'b0, 16'hFFFE, 8'h7F, 1'b1, ST_BAD_CRC},
            '{1'b0, 8'h00, 8'h00, 0, SH_BOTH_BAD,   1'b0, 16'h00FF, 8'hAA, 1'b1, ST_BAD_TAIL},
            // body made of header values: no resync inside a frame
            '{1'b1, 8'h55, 8'hAA, 3, SH_GOOD,       1'b0, 16'h5555, 8'h55, 1'b1, ST_OK},
            '{1'b1, 8'h00, 8'hFF, 1, SH_GOOD,       1'b1, 16'h0000, 8'h00, 1'b0, ST_OK},
            '{1'b1, 8'h3C, 8'h00, 2, SH_BAD_CRC_LO, 1'b1, 16'h0000, 8'h00, 1'b0, ST_OK}
        };

        // Hold reset low from time zero, then release.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].set_cfg) begin
                settle();
                program_regs(plan[i].hdr, plan[i].tail);
            end
            pin.typed            = plan[i].typed;
            pin.res              = '0;
            pin.res.frame_status = plan[i].status;
            if (plan[i].status == ST_OK) begin
                pin.res.distance_a   = plan[i].word;
                pin.res.distance_b   = plan[i].word;
                pin.res.distance_c   = plan[i].word;
                pin.res.distance_d   = plan[i].word;
                pin.res.distance_e   = plan[i].word;
                pin.res.switch_state = plan[i].sw;
                pin.res.temperature  = plan[i].word;
                pin.res.humidity     = plan[i].word;
                pin.res.particulate  = plan[i].word;
            end
            pinned_q.push_back(pin);
            queue_noise(plan[i].noise, 1'b0);
            queue_frame(plan[i].shape, plan[i].rand_body, plan[i].word, plan[i].sw, FRAME_LEN);
        end
        settle();

        // Random phases: mostly well-formed frames with random bodies, the rest damaged
        // frames, stray garbage and frames cut short. A cut frame followed by a register
        // write puts the write in the middle of a frame.
        base_beats   = beats_in;
        phase        = 0;
        while (beats_in - base_beats < RAND_BEATS) begin
            if (phase == 2) begin
                // Hold off the receiver while back-to-back frames pile up behind it.
                settle();
                hold_req = 1'b1;
                repeat (4) queue_frame(SH_GOOD, 1'b1, 16'h0000, 8'h00, FRAME_LEN);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    settle();
                    case ($urandom_range(0, 3))
                        0: hdr = 8'h00;
                        1: hdr = 8'hFF;
                        default: hdr = 8'($urandom_range(0, 255));
                    endcase
                    case ($urandom_range(0, 3))
                        0: tl = 8'h00;
                        1: tl = 8'hFF;
                        default: tl = 8'($urandom_range(0, 255));
                    endcase
                    program_regs(hdr, tl);
                end else begin
                    // Keep the beat queue short so phases track the block.
                    while (rx_stream.size() > 48) @(posedge i_clk);
                end
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8) begin
                        queue_noise($urandom_range(1, 30), 1'b1);
                    end else begin
                        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 3), 1'b0);
                        if (pick < 72) begin
                            shape = SH_GOOD;
                        end else if (pick < 80) begin
                            shape = SH_BAD_TAIL;
                        end else if (pick < 86) begin
                            shape = SH_BAD_CRC_LO;
                        end else if (pick < 92) begin
                            shape = SH_BAD_CRC_HI;
                        end else begin
                            shape = SH_BOTH_BAD;
                        end
                        queue_frame(shape, 1'b1, 16'h0000, 8'h00, FRAME_LEN);
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_frame(SH_GOOD, 1'b1, 16'h0000, 8'h00, $urandom_range(1, FRAME_LEN - 1));
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
design/sfr_pkg.sv
design/sfr_byte_if.sv
design/sfr_result_if.sv
design/sfr_collector.sv
design/sfr_out_reg.sv
design/sensor_frame_receiver_crc16.sv
design/sfr_checker.sv
dv/tb.sv
